// ----- sv/multi_channel_servo_pwm_unit_defines.svh -----
// ---------------------------------------------------------------------------
// multi_channel_servo_pwm_unit assertion macros
// Concurrent assertion wrappers clocked on clk, with or without reset gating.
// ---------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_SERVO_PWM_UNIT_DEFINES_SVH
`define MULTI_CHANNEL_SERVO_PWM_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define MCSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MCSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCSP_ASSERT(lbl, prop, msg)
`define MCSP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- sv/mcsp_pkg.sv -----
// ---------------------------------------------------------------------------
// mcsp_pkg
// Widths, reset values, register indexes and result type of the servo unit.
// ---------------------------------------------------------------------------
package mcsp_pkg;

  localparam int TICK_W      = 12;
  localparam int SEL_W       = 3;
  localparam int FRAME_W     = 10;
  localparam int PIN_W       = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 12;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int RESULT_W    = PIN_W + 1 + FRAME_W;

  localparam logic [TICK_W-1:0] POS_RESET    = 12'd54;
  localparam logic [TICK_W-1:0] PERIOD_RESET = 12'd2000;
  localparam logic [TICK_W-1:0] DEAD_RESET   = 12'd250;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIME_START = 1'b1;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // packed so that pin_levels sits in the lowest bits
  typedef struct packed {
    logic [FRAME_W-1:0] frame_count;
    logic               dead_time;
    logic [PIN_W-1:0]   pin_levels;
  } result_t;

endpackage

// ----- sv/multi_channel_servo_pwm_unit.sv -----
// ---------------------------------------------------------------------------
// multi_channel_servo_pwm_unit
// Multi-channel servo pulse generator with a tick/position-write stream in.
// ---------------------------------------------------------------------------
// The unit takes one transfer per clock cycle while in_tready is high, tick
// or position write, and answers each with one registered result transfer
// (pin levels, dead-time flag, frame count). All state updates for a
// transfer happen in the cycle it is accepted; the result goes into a
// two-entry output buffer, so input transfers keep flowing while one result
// waits, and in_tready only drops once both buffer entries are full.
`include "multi_channel_servo_pwm_unit_defines.svh"

module multi_channel_servo_pwm_unit #(
  parameter int CHANNELS   = 8,
  parameter int FRAME_WRAP = 1000
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wen,
  input  logic [mcsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mcsp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [2:0] channel_sel, [14:3] position_value, [15] zero
  input  logic [mcsp_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] req_type
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] pin_levels, [8] dead_time, [18:9] frame_count, [23:19] zero
  output logic [mcsp_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  import mcsp_pkg::*;

  localparam int PAD_W = (CHANNELS > PIN_W) ? CHANNELS : PIN_W;

  logic [TICK_W-1:0]   period_r;
  logic [TICK_W-1:0]   dead_start_r;
  logic [TICK_W-1:0]   tick_r, tick_nxt, tick_inc;
  logic [CHANNELS-1:0] levels_r, levels_nxt;
  logic [TICK_W-1:0]   pos_r [CHANNELS];
  logic [FRAME_W-1:0]  frame_r, frame_nxt;
  logic [FRAME_W:0]    frame_inc;
  logic                dead_r, dead_nxt;
  logic [PAD_W-1:0]    levels_ext;

  logic                in_acc, out_acc, is_tick, frame_end, frame_acc;
  logic [SEL_W-1:0]    in_sel;
  logic [TICK_W-1:0]   in_pos;
  result_t             res_nxt, out_r, skid_r;
  logic                out_valid_r, skid_valid_r;

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign in_sel    = in_tdata[SEL_W-1:0];
  assign in_pos    = in_tdata[SEL_W+TICK_W-1:SEL_W];
  assign is_tick   = (in_tuser == REQ_TICK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r     <= PERIOD_RESET;
      dead_start_r <= DEAD_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_PERIOD_TICKS:    period_r     <= cfg_wdata;
        REG_DEAD_TIME_START: dead_start_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign tick_inc  = tick_r + 1'b1;
  assign frame_end = (tick_inc == period_r);
  assign frame_acc = in_acc && is_tick && frame_end;
  assign frame_inc = {1'b0, frame_r} + 1'b1;

  always_comb begin
    tick_nxt   = tick_r;
    levels_nxt = levels_r;
    dead_nxt   = dead_r;
    frame_nxt  = frame_r;
    if (is_tick) begin
      tick_nxt = tick_inc;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        if (pos_r[ch] == tick_inc) levels_nxt[ch] = 1'b0;
      end
      if (tick_inc == dead_start_r) dead_nxt = 1'b1;
      if (frame_end) begin
        tick_nxt   = '0;
        levels_nxt = '1;
        dead_nxt   = 1'b0;
        frame_nxt  = (frame_inc == (FRAME_W+1)'(FRAME_WRAP)) ? '0 : frame_inc[FRAME_W-1:0];
      end
    end
  end

  assign levels_ext          = PAD_W'(levels_nxt);
  assign res_nxt.pin_levels  = levels_ext[PIN_W-1:0];
  assign res_nxt.dead_time   = dead_nxt;
  assign res_nxt.frame_count = frame_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '0;
      levels_r <= '0;
      dead_r   <= 1'b0;
      frame_r  <= '0;
      for (int ch = 0; ch < CHANNELS; ch++) pos_r[ch] <= POS_RESET;
    end else if (in_acc) begin
      tick_r   <= tick_nxt;
      levels_r <= levels_nxt;
      dead_r   <= dead_nxt;
      frame_r  <= frame_nxt;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        if (!is_tick && int'(in_sel) == ch) pos_r[ch] <= in_pos;
      end
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      priority if (out_acc && skid_valid_r) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end else if (out_acc) begin
        out_valid_r <= in_acc;
        if (in_acc) out_r <= res_nxt;
      end else if (in_acc && !out_valid_r) begin
        out_r       <= res_nxt;
        out_valid_r <= 1'b1;
      end else if (in_acc) begin
        skid_r       <= res_nxt;
        skid_valid_r <= 1'b1;
      end else begin
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_r);

  `MCSP_ASSERT(a_skid_needs_out, skid_valid_r |-> out_valid_r, "skid without output entry")
  `MCSP_ASSERT(a_frame_in_range, frame_r <= FRAME_W'(FRAME_WRAP - 1), "frame counter past wrap")
  `MCSP_ASSERT(a_frame_restart, frame_acc |=> (tick_r == '0 && levels_r == '1), "no frame restart")
  `MCSP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_tvalid && in_tready), "not empty after reset")

endmodule
